/* rtl/core/asd_pkg.sv */
// ----------------------------------------------------------------------------
// Shake detector package
// Shared item types, register indexes and fixed constants of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package asd_pkg;

	localparam int RAW_W       = 16;
	localparam int SHIFT_AMOUNT = 6;
	localparam int AXIS_W      = RAW_W - SHIFT_AMOUNT;
	localparam int THR_W       = 10;
	localparam int COUNT_W     = 7;
	localparam int CFG_IDX_W   = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;
	localparam logic [THR_W-1:0]   SHAKE_RESET = 10'd180;
	localparam logic [THR_W-1:0]   QUIET_RESET = 10'd50;

	localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET_THRESHOLD = 1'b1;

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef axis_t [2:0] axes_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
		logic signed [RAW_W-1:0] raw_z;
		logic                    first_of_batch;
	} sample_t;

	typedef struct packed {
		logic tap_event;
		logic is_shaking;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/asd_vote.sv */
// ----------------------------------------------------------------------------
// Two-of-three motion vote
// Flags a sample when at least two axes moved by more than a limit since the
// previous sample.
// ----------------------------------------------------------------------------
`default_nettype none

module asd_vote
	import asd_pkg::*;
(
	input  wire axes_t            now,
	input  wire axes_t            prev,
	input  wire logic [THR_W-1:0] limit,
	output logic                  hit
);

	logic [2:0] over;

	always_comb begin
		logic signed [AXIS_W:0] diff;
		logic [AXIS_W:0]        mag;
		for (int i = 0; i < 3; i++) begin
			diff = {prev[i][AXIS_W-1], prev[i]} - {now[i][AXIS_W-1], now[i]};
			mag = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : (AXIS_W+1)'(diff);
			over[i] = mag > (AXIS_W+1)'(limit);
		end
	end

	assign hit = (over[0] & over[1]) | (over[0] & over[2]) | (over[1] & over[2]);

endmodule

`default_nettype wire

/* rtl/core/accel_shake_detector.sv */
// ----------------------------------------------------------------------------
// Accelerometer shake detector
// Scales three-axis samples, votes on per-axis motion against two thresholds
// and reports tap events and the shaking flag, one result per sample.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                              Direction  Payload
//   sample    sample_valid, sample_stall, sample   in         sample_t
//   result    result_valid, result_stall, result   out        result_t
//   config    cfg_wr_en, cfg_index, cfg_data       in         10-bit threshold
//
// One item is accepted per cycle while sample_stall is low; its result passes
// through the input register and then the result register.
// Reset clears the thresholds to their defaults and the stored sample, count
// and flag to zero.
// A stall on the result side holds the result register, and the input side
// stalls only while its register is full and cannot move on.
`default_nettype none

module accel_shake_detector
	import asd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_stall,
	input  wire sample_t              sample,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [THR_W-1:0]     cfg_data
);

	logic [THR_W-1:0]   shake_thr_q;
	logic [THR_W-1:0]   quiet_thr_q;
	axes_t              axes_s1;
	logic               first_s1;
	logic               valid_s1;
	axes_t              prev_q;
	logic [COUNT_W-1:0] count_q;
	logic               shaking_q;
	logic               out_free;
	logic               advance;
	logic               shake_hit;
	logic               quiet_hit;
	logic               tap;
	logic [COUNT_W-1:0] count_next;
	logic               shaking_next;

	assign out_free     = !result_valid || !result_stall;
	assign advance      = valid_s1 && out_free;
	assign sample_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shake_thr_q <= SHAKE_RESET;
			quiet_thr_q <= QUIET_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SHAKE_THRESHOLD: shake_thr_q <= cfg_data;
				CFG_QUIET_THRESHOLD: quiet_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			axes_s1[0] <= sample.raw_x[RAW_W-1:SHIFT_AMOUNT];
			axes_s1[1] <= sample.raw_y[RAW_W-1:SHIFT_AMOUNT];
			axes_s1[2] <= sample.raw_z[RAW_W-1:SHIFT_AMOUNT];
			first_s1   <= sample.first_of_batch;
		end
	end

	asd_vote u_shake_vote (
		.now   (axes_s1),
		.prev  (prev_q),
		.limit (shake_thr_q),
		.hit   (shake_hit)
	);

	asd_vote u_quiet_vote (
		.now   (axes_s1),
		.prev  (prev_q),
		.limit (quiet_thr_q),
		.hit   (quiet_hit)
	);

	always_comb begin
		tap          = 1'b0;
		count_next   = count_q;
		shaking_next = shaking_q;
		if (!first_s1) begin
			if (!shaking_q && count_q != '0 && shake_hit) begin
				tap          = 1'b1;
				shaking_next = 1'b1;
				count_next   = '0;
			end else if (shake_hit) begin
				if (count_q != COUNT_MAX) begin
					count_next = count_q + COUNT_W'(1);
				end
			end else if (!quiet_hit) begin
				count_next   = '0;
				shaking_next = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			count_q   <= '0;
			shaking_q <= 1'b0;
		end else if (advance) begin
			prev_q    <= axes_s1;
			count_q   <= count_next;
			shaking_q <= shaking_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.tap_event  <= tap;
			result.is_shaking <= shaking_next;
		end
	end

	a_tap_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.tap_event || result.is_shaking))
		else $error("A tap item was reported without the shaking flag.");

	a_rise_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(shaking_q) |-> count_q == '0)
		else $error("The shake count was not cleared when shaking began.");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("The sample side stalled with room in the pipeline.");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(count_q) && $stable(shaking_q) && $stable(prev_q)))
		else $error("Detector state changed without an item moving on.");

endmodule

`default_nettype wire
